// ===== rtl/mst_pkg.sv =====
// shared types and opcodes for the module state upsert table
package mst_pkg;

	localparam int KEY_W   = 32;
	localparam int STATE_W = 3;
	localparam int OP_W    = 2;

	localparam logic [OP_W-1:0] OP_UPDATE = 2'd0;
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

	localparam logic [STATE_W-1:0] STATE_STOPPED = 3'd0;

	// one item travelling down the cell chain
	typedef struct packed {
		logic               vld;
		logic [OP_W-1:0]    op;
		logic [KEY_W-1:0]   unit_key;
		logic [KEY_W-1:0]   module_key;
		logic [STATE_W-1:0] new_run_state;
		logic               done;
		logic [STATE_W-1:0] run_state;
	} item_t;

endpackage

// ===== rtl/mst_cell.sv =====
// one table entry plus the chain stage that carries items past it
module mst_cell
	import mst_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  logic  last_cell,
	input  item_t prev,
	output item_t nxt
);

	logic               ent_vld_q;
	logic [KEY_W-1:0]   ent_ukey_q;
	logic [KEY_W-1:0]   ent_mkey_q;
	logic [STATE_W-1:0] ent_state_q;
	item_t              stage_s1;

	logic  key_hit;
	logic  upd_hit;
	logic  upd_alloc;
	logic  lkp_hit;
	logic  lkp_miss_end;
	item_t item_d;

	assign key_hit = ent_vld_q && (ent_ukey_q == prev.unit_key)
		&& (ent_mkey_q == prev.module_key);

	always_comb begin
		upd_hit      = 1'b0;
		upd_alloc    = 1'b0;
		lkp_hit      = 1'b0;
		lkp_miss_end = 1'b0;
		item_d       = prev;
		if (prev.vld && !prev.done) begin
			if (prev.op == OP_UPDATE) begin
				// match rewrites state; first free slot or the last slot takes a new entry
				upd_hit   = key_hit;
				upd_alloc = !key_hit && (!ent_vld_q || last_cell);
				item_d.done = upd_hit || upd_alloc;
			end else if (prev.op == OP_LOOKUP) begin
				lkp_hit      = key_hit;
				// valid entries form a prefix, so an empty slot ends the search
				lkp_miss_end = !ent_vld_q;
				item_d.done  = lkp_hit || lkp_miss_end;
				if (lkp_hit) begin
					item_d.run_state = ent_state_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= 1'b0;
			stage_s1  <= '0;
		end else if (adv) begin
			stage_s1 <= item_d;
			if (prev.vld && prev.op == OP_CLEAR) begin
				ent_vld_q <= 1'b0;
			end else if (upd_alloc) begin
				ent_vld_q <= 1'b1;
			end
		end
	end

	// entry payload, written only by updates
	always_ff @(posedge clk) begin
		if (adv) begin
			if (upd_alloc) begin
				ent_ukey_q <= prev.unit_key;
				ent_mkey_q <= prev.module_key;
			end
			if (upd_alloc || upd_hit) begin
				ent_state_q <= prev.new_run_state;
			end
		end
	end

	assign nxt = stage_s1;

endmodule

// ===== rtl/module_state_upsert_table_top.sv =====
// top level: chain of table cells with an output result register
// path: each cell's chain stage register in turn, then the output result register
// throughput: one item per cycle while no result waits at the output; each cell holds one entry and passes the item on
// the whole chain stalls while a result waits at the output
// reset: all entries invalid (table empty), no items in flight, no result pending
// only lookups give a result; update, clear and unused opcodes leave the chain silently
module module_state_upsert_table_top
	import mst_pkg::*;
#(
	parameter int ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // unit_key[31:0], module_key[63:32], new_run_state[66:64], zero pad
	input  logic [1:0]  s_tuser,  // opcode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // run_state_out[2:0], zero pad
);

	item_t chain [ENTRIES+1];
	item_t tail;

	logic               adv;
	logic               m_tvalid_q;
	logic [STATE_W-1:0] run_state_q;

	// the chain moves whenever the output register is free or being drained
	assign adv      = !m_tvalid_q || m_tready;
	assign s_tready = adv;

	// item entering the first cell
	always_comb begin
		chain[0]               = '0;
		chain[0].vld           = s_tvalid;
		chain[0].op            = s_tuser;
		chain[0].unit_key      = s_tdata[31:0];
		chain[0].module_key    = s_tdata[63:32];
		chain[0].new_run_state = s_tdata[66:64];
		chain[0].done          = 1'b0;
		chain[0].run_state     = STATE_STOPPED;
	end

	// one cell per entry; the last one overwrites when the table is full
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		mst_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.last_cell (i == ENTRIES - 1),
			.prev      (chain[i]),
			.nxt       (chain[i+1])
		);
	end

	assign tail = chain[ENTRIES];

	// result register: only lookups leaving the chain produce a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= tail.vld && (tail.op == OP_LOOKUP);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			run_state_q <= tail.run_state;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(8 - STATE_W){1'b0}}, run_state_q};

	// a lookup leaving the chain always becomes a pending result
	a_lookup_out : assert property (@(posedge clk) disable iff (!arst_n)
		adv && tail.vld && (tail.op == OP_LOOKUP) |=> m_tvalid)
		else $error("lookup left the chain without a result");

	// nothing else ever raises a result
	a_no_spurious : assert property (@(posedge clk) disable iff (!arst_n)
		adv && !(tail.vld && (tail.op == OP_LOOKUP)) |=> !m_tvalid)
		else $error("result raised without a lookup");

	// an item that found no entry carries the stopped code
	a_miss_stopped : assert property (@(posedge clk) disable iff (!arst_n)
		tail.vld && !tail.done |-> tail.run_state == STATE_STOPPED)
		else $error("unmatched item carries a nonzero state");

endmodule
